### rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg: shared types and codes of the UTF-32 to UTF-16 converter
// Register indexes, result kinds, counting phases and the record that passes
// from the front end to the result sequencer.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_CAPACITY    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_REQUIRED  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_TERMINATED = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_INPUT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_OUTPUT     = 3'd4;

  localparam logic [1:0] KIND_UNIT      = 2'd0;
  localparam logic [1:0] KIND_DONE      = 2'd1;
  localparam logic [1:0] KIND_INVALID   = 2'd2;
  localparam logic [1:0] KIND_TOO_SMALL = 2'd3;

  localparam logic [1:0] PH_CONVERT = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;

  typedef struct packed {
    logic [15:0] out_capacity;
    logic        count_required;
    logic        zero_terminated;
    logic        swap_input;
    logic        swap_output;
  } u2u_cfg_t;

  // All results caused by one request: up to two code units, then possibly a status.
  typedef struct packed {
    logic [1:0]  n_units;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic [15:0] wc0;
    logic [15:0] wc1;
    logic [31:0] unit_index;
    logic        has_status;
    logic [1:0]  st_kind;
    logic [31:0] st_ret;
    logic [31:0] st_res;
    logic [15:0] st_wc;
  } u2u_entry_t;

  typedef struct packed {
    logic       valid;
    u2u_entry_t entry;
  } u2u_push_t;

endpackage

### rtl/u2u_in_if.sv
// ----------------------------------------------------------------------------
// u2u_in_if: input channel of the converter
// One UTF-32 word per request, with its end-of-string flag.
// ----------------------------------------------------------------------------
interface u2u_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        end_of_string;

  modport source (output valid, code_word, end_of_string, input ready);
  modport sink (input valid, code_word, end_of_string, output ready);
endinterface

### rtl/u2u_out_if.sv
// ----------------------------------------------------------------------------
// u2u_out_if: result channel of the converter
// Code units and status results with their sizes and indexes.
// ----------------------------------------------------------------------------
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] unit_value;
  logic [31:0] return_size;
  logic [31:0] resume_index;
  logic [15:0] units_written;
  logic        run_end;

  modport source (output valid, kind, unit_value, return_size, resume_index,
                  units_written, run_end, input ready);
  modport sink (input valid, kind, unit_value, return_size, resume_index,
                units_written, run_end, output ready);
endinterface

### rtl/u2u_cfg_if.sv
// ----------------------------------------------------------------------------
// u2u_cfg_if: register write channel of the converter
// Register index and write data, one write per request.
// ----------------------------------------------------------------------------
interface u2u_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/u2u_cfg_regs.sv
// ----------------------------------------------------------------------------
// u2u_cfg_regs: configuration registers
// Takes register writes and holds the settings used by the front end.
// ----------------------------------------------------------------------------
module u2u_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  u2u_cfg_if.sink          cfg_ch,
  output u2u_pkg::u2u_cfg_t cfg
);

  u2u_pkg::u2u_cfg_t cfg_r;
  u2u_pkg::u2u_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        u2u_pkg::CFG_OUT_CAPACITY:    cfg_nxt.out_capacity    = cfg_ch.data[15:0];
        u2u_pkg::CFG_COUNT_REQUIRED:  cfg_nxt.count_required  = cfg_ch.data[0];
        u2u_pkg::CFG_ZERO_TERMINATED: cfg_nxt.zero_terminated = cfg_ch.data[0];
        u2u_pkg::CFG_SWAP_INPUT:      cfg_nxt.swap_input      = cfg_ch.data[0];
        u2u_pkg::CFG_SWAP_OUTPUT:     cfg_nxt.swap_output     = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_capacity    <= 16'hFFFF;
      cfg_r.count_required  <= 1'b0;
      cfg_r.zero_terminated <= 1'b1;
      cfg_r.swap_input      <= 1'b0;
      cfg_r.swap_output     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front: input classifier and string bookkeeping
// Decodes each word, keeps the per-string counters and builds the record of
// all results that the word causes.
// ----------------------------------------------------------------------------
module u2u_front #(
  parameter int COUNT_WIDTH = u2u_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  u2u_pkg::u2u_cfg_t  cfg,
  u2u_in_if.sink             in_ch,
  input  logic               q_full,
  output u2u_pkg::u2u_push_t push
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_add(input cnt_t a, input logic [1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {{(COUNT_WIDTH - 1){1'b0}}, b};
    sat_add = s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic cnt_t ext16(input logic [15:0] w);
    logic [COUNT_WIDTH+15:0] t;
    t = {{COUNT_WIDTH{1'b0}}, w};
    ext16 = t[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] low32(input cnt_t x);
    logic [COUNT_WIDTH+31:0] t;
    t = {32'b0, x};
    low32 = t[31:0];
  endfunction

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] wc_r, wc_nxt;
  cnt_t        idx_r, idx_nxt;
  cnt_t        resume_r, resume_nxt;
  cnt_t        req_r, req_nxt;

  logic        accept;
  logic [31:0] c;
  logic        eos, bad, supp;
  logic [19:0] supp_off;
  logic [15:0] hi_unit, lo_unit, u0, u1;
  logic [15:0] wc_plus1, wc_plus2, wc_new;
  logic        restart;
  cnt_t        idx_inc, req_base, resume_base, req_new;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    c = in_ch.code_word;
    if (cfg.swap_input) begin
      c = {in_ch.code_word[7:0], in_ch.code_word[15:8],
           in_ch.code_word[23:16], in_ch.code_word[31:24]};
    end
  end

  assign eos  = cfg.zero_terminated ? (c == 32'd0) : in_ch.end_of_string;
  assign bad  = (c > 32'h0010_FFFF) || ((c >= 32'h0000_D800) && (c <= 32'h0000_DFFF));
  assign supp = c > 32'h0000_FFFF;

  assign supp_off = c[19:0] - 20'h1_0000;
  assign hi_unit  = {6'b110110, supp_off[19:10]};
  assign lo_unit  = {6'b110111, c[9:0]};
  assign u0       = supp ? hi_unit : c[15:0];
  assign u1       = lo_unit;
  assign wc_plus1 = wc_r + 16'd1;
  assign wc_plus2 = wc_r + 16'd2;
  assign wc_new   = supp ? wc_plus2 : wc_plus1;
  assign idx_inc  = sat_add(idx_r, 2'd1);

  always_comb begin
    phase_nxt   = phase_r;
    wc_nxt      = wc_r;
    idx_nxt     = idx_r;
    resume_nxt  = resume_r;
    req_nxt     = req_r;
    restart     = 1'b0;
    push        = '0;
    req_base    = req_r;
    resume_base = resume_r;
    req_new     = req_r;

    push.entry.unit0      = cfg.swap_output ? {u0[7:0], u0[15:8]} : u0;
    push.entry.unit1      = cfg.swap_output ? {u1[7:0], u1[15:8]} : u1;
    push.entry.wc0        = wc_plus1;
    push.entry.wc1        = wc_plus2;
    push.entry.unit_index = low32(idx_r);
    push.entry.st_wc      = wc_r;

    if (accept) begin
      if ((phase_r != u2u_pkg::PH_COUNT) && (wc_r < cfg.out_capacity)) begin
        if (bad) begin
          push.valid            = 1'b1;
          push.entry.has_status = 1'b1;
          push.entry.st_kind    = u2u_pkg::KIND_INVALID;
          push.entry.st_res     = low32(idx_r);
          restart               = 1'b1;
        end else if (supp && (({1'b0, wc_r} + 17'd1) == {1'b0, cfg.out_capacity})) begin
          // A surrogate pair that no longer fits in the last free unit.
          if (!cfg.count_required || eos) begin
            push.valid            = 1'b1;
            push.entry.has_status = 1'b1;
            push.entry.st_kind    = u2u_pkg::KIND_TOO_SMALL;
            push.entry.st_ret     = low32(sat_add(ext16(wc_r), 2'd2));
            push.entry.st_res     = low32(idx_r);
            restart               = 1'b1;
          end else begin
            phase_nxt  = u2u_pkg::PH_COUNT;
            req_nxt    = sat_add(ext16(wc_r), 2'd2);
            resume_nxt = idx_r;
            idx_nxt    = idx_inc;
          end
        end else begin
          push.valid         = 1'b1;
          push.entry.n_units = supp ? 2'd2 : 2'd1;
          push.entry.st_wc   = wc_new;
          if (eos) begin
            push.entry.has_status = 1'b1;
            push.entry.st_kind    = u2u_pkg::KIND_DONE;
            push.entry.st_ret     = low32(ext16(wc_new));
            push.entry.st_res     = low32(idx_inc);
            restart               = 1'b1;
          end else if (wc_new >= cfg.out_capacity) begin
            if (!cfg.count_required) begin
              push.entry.has_status = 1'b1;
              push.entry.st_kind    = u2u_pkg::KIND_TOO_SMALL;
              push.entry.st_ret     = low32(sat_add(ext16(wc_new), 2'd1));
              push.entry.st_res     = low32(idx_inc);
              restart               = 1'b1;
            end else begin
              phase_nxt  = u2u_pkg::PH_COUNT;
              wc_nxt     = wc_new;
              req_nxt    = ext16(wc_new);
              resume_nxt = idx_inc;
              idx_nxt    = idx_inc;
            end
          end else begin
            wc_nxt  = wc_new;
            idx_nxt = idx_inc;
          end
        end
      end else begin
        // Counting only; a string that has just run out of room starts its
        // count at the units already written.
        if (phase_r != u2u_pkg::PH_COUNT) begin
          req_base    = ext16(wc_r);
          resume_base = idx_r;
        end
        req_new = sat_add(req_base, supp ? 2'd2 : 2'd1);
        if (bad) begin
          push.valid            = 1'b1;
          push.entry.has_status = 1'b1;
          push.entry.st_kind    = u2u_pkg::KIND_INVALID;
          push.entry.st_res     = low32(idx_r);
          restart               = 1'b1;
        end else if (eos) begin
          push.valid            = 1'b1;
          push.entry.has_status = 1'b1;
          push.entry.st_kind    = u2u_pkg::KIND_TOO_SMALL;
          push.entry.st_ret     = low32(req_new);
          push.entry.st_res     = low32(resume_base);
          restart               = 1'b1;
        end else begin
          phase_nxt  = u2u_pkg::PH_COUNT;
          req_nxt    = req_new;
          resume_nxt = resume_base;
          idx_nxt    = idx_inc;
        end
      end
    end

    if (restart) begin
      phase_nxt  = u2u_pkg::PH_CONVERT;
      wc_nxt     = '0;
      idx_nxt    = '0;
      resume_nxt = '0;
      req_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= u2u_pkg::PH_CONVERT;
      wc_r     <= '0;
      idx_r    <= '0;
      resume_r <= '0;
      req_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      wc_r     <= wc_nxt;
      idx_r    <= idx_nxt;
      resume_r <= resume_nxt;
      req_r    <= req_nxt;
    end
  end

endmodule

### rtl/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue: short queue between front end and result sequencer
// Holds result records so that input and output can stall independently.
// ----------------------------------------------------------------------------
module u2u_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  u2u_pkg::u2u_push_t  push,
  output logic                full,
  output logic                head_valid,
  output u2u_pkg::u2u_entry_t head,
  input  logic                pop
);

  localparam int CNT_W = $clog2(u2u_pkg::QUEUE_DEPTH + 1);
  localparam int PTR_W = u2u_pkg::QPTR_W;

  u2u_pkg::u2u_entry_t slot_r [u2u_pkg::QUEUE_DEPTH];
  logic [u2u_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u2u_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       do_push, do_pop;

  assign full       = (count_r == CNT_W'(u2u_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back: result sequencer
// Walks through the results of the record at the head of the queue, one per
// cycle while the result channel is not stalled, into the output register.
// ----------------------------------------------------------------------------
module u2u_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  u2u_pkg::u2u_entry_t head,
  output logic                pop,
  u2u_out_if.source           out_ch
);

  logic [1:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic [15:0] unit_r;
  logic [31:0] ret_r;
  logic [31:0] res_r;
  logic [15:0] wc_r;
  logic        run_end_r;

  logic [1:0]  total;
  logic        last, load, is_unit;
  logic [1:0]  cur_kind;
  logic [15:0] cur_unit;
  logic [31:0] cur_ret;
  logic [31:0] cur_res;
  logic [15:0] cur_wc;

  assign total   = head.n_units + {1'b0, head.has_status};
  assign last    = (step_r == (total - 2'd1));
  assign load    = head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = load && last;
  assign is_unit = (step_r < head.n_units);

  always_comb begin
    cur_kind = head.st_kind;
    cur_unit = '0;
    cur_ret  = head.st_ret;
    cur_res  = head.st_res;
    cur_wc   = head.st_wc;
    if (is_unit) begin
      cur_kind = u2u_pkg::KIND_UNIT;
      cur_unit = (step_r == 2'd0) ? head.unit0 : head.unit1;
      cur_ret  = '0;
      cur_res  = head.unit_index;
      cur_wc   = (step_r == 2'd0) ? head.wc0 : head.wc1;
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = last ? 2'd0 : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r    <= cur_kind;
      unit_r    <= cur_unit;
      ret_r     <= cur_ret;
      res_r     <= cur_res;
      wc_r      <= cur_wc;
      run_end_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.unit_value    = unit_r;
  assign out_ch.return_size   = ret_r;
  assign out_ch.resume_index  = res_r;
  assign out_ch.units_written = wc_r;
  assign out_ch.run_end       = run_end_r;

endmodule

### rtl/utf32_to_utf16_converter.sv
// ----------------------------------------------------------------------------
// utf32_to_utf16_converter: UTF-32 to UTF-16 transcoder, bounded destination
// Front end classifies words and keeps string counters; a four-entry queue
// feeds a sequencer that delivers results through an output register.
// ----------------------------------------------------------------------------
// The front end takes one word per cycle whenever its queue has room, and the
// result port delivers one result per cycle while it is not stalled, so the
// sustained rate is set by the number of results: a word in the basic plane
// gives one result, a surrogate pair two, and a status result one more.
// Words counted after the room has run out produce no result. The first result
// of a word is registered in the queue and then in the output register before
// it reaches the result port. Counters are COUNT_WIDTH bits wide and saturate;
// outputs carry their low 32 bits.
module utf32_to_utf16_converter #(
  parameter int COUNT_WIDTH = u2u_pkg::COUNT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  u2u_in_if.sink    in_ch,
  u2u_out_if.source out_ch,
  u2u_cfg_if.sink   cfg_ch
);

  u2u_pkg::u2u_cfg_t   cfg;
  u2u_pkg::u2u_push_t  push;
  u2u_pkg::u2u_entry_t head;
  logic                q_full;
  logic                head_valid;
  logic                pop;

  u2u_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  u2u_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  u2u_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  u2u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the UTF-32 to UTF-16 converter
// A scoreboard class predicts every code unit and status result from each
// accepted word and the current register settings, and checks the results in
// order. A short directed sequence covers the code point boundaries, the
// capacity corner cases and byte swapping. Random strings follow under
// several register settings, with random idling on both channels and one
// long stall of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 16;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] unit_value;
    logic [31:0] return_size;
    logic [31:0] resume_index;
    logic [15:0] units_written;
    logic        run_end;
  } utf16_result_t;

  class utf16_scoreboard;
    logic [15:0]   capacity;
    bit            keep_counting;
    bit            zero_term;
    bit            swap_in;
    bit            swap_out;
    logic [1:0]    phase;
    logic [15:0]   written;
    logic [31:0]   word_pos;
    logic [31:0]   resume_pos;
    logic [31:0]   needed;
    utf16_result_t owed[$];
    int            errors;

    function new();
      capacity      = 16'hFFFF;
      keep_counting = 1'b0;
      zero_term     = 1'b1;
      swap_in       = 1'b0;
      swap_out      = 1'b0;
      errors        = 0;
      start_string();
    endfunction

    function void start_string();
      phase      = u2u_pkg::PH_CONVERT;
      written    = '0;
      word_pos   = '0;
      resume_pos = '0;
      needed     = '0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        u2u_pkg::CFG_OUT_CAPACITY:    capacity = data[15:0];
        u2u_pkg::CFG_COUNT_REQUIRED:  keep_counting = data[0];
        u2u_pkg::CFG_ZERO_TERMINATED: zero_term = data[0];
        u2u_pkg::CFG_SWAP_INPUT:      swap_in = data[0];
        u2u_pkg::CFG_SWAP_OUTPUT:     swap_out = data[0];
        default: ;
      endcase
    endfunction

    // Counts saturate at all ones rather than wrapping.
    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function void add_result(logic [1:0] kind, logic [15:0] unit_value,
                             logic [31:0] ret, logic [31:0] res, logic last);
      utf16_result_t r;
      r.kind          = kind;
      r.unit_value    = unit_value;
      r.return_size   = ret;
      r.resume_index  = res;
      r.units_written = written;
      r.run_end       = last;
      owed.push_back(r);
    endfunction

    function void add_unit(logic [15:0] u);
      written = written + 16'd1;
      add_result(u2u_pkg::KIND_UNIT, swap_out ? {u[7:0], u[15:8]} : u, '0, word_pos,
                 1'b0);
    endfunction

    function void close_string(logic [1:0] kind, logic [31:0] ret, logic [31:0] res);
      add_result(kind, '0, ret, res, 1'b1);
      start_string();
    endfunction

    function void note_word(logic [31:0] word, logic flag);
      logic [31:0] c;
      logic [31:0] off;
      bit          last_word;
      bit          bad;
      c = swap_in ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
      last_word = zero_term ? (c == 32'd0) : flag;
      bad = (c > 32'h0010_FFFF) || (c >= 32'hD800 && c <= 32'hDFFF);
      if (phase != u2u_pkg::PH_COUNT) begin
        if (written >= capacity) begin
          // The room was lowered under the units already written.
          phase      = u2u_pkg::PH_COUNT;
          needed     = {16'd0, written};
          resume_pos = word_pos;
        end else begin
          if (bad) begin
            close_string(u2u_pkg::KIND_INVALID, '0, word_pos);
            return;
          end
          if (c > 32'h0000_FFFF) begin
            if ({1'b0, written} + 17'd1 == {1'b0, capacity}) begin
              // Only one unit of room left: the pair is not split.
              if (!keep_counting || last_word) begin
                close_string(u2u_pkg::KIND_TOO_SMALL, sat_add({16'd0, written}, 32'd2),
                             word_pos);
                return;
              end
              phase      = u2u_pkg::PH_COUNT;
              needed     = {16'd0, written} + 32'd2;
              resume_pos = word_pos;
              word_pos   = sat_add(word_pos, 32'd1);
              return;
            end
            off = c - 32'h0001_0000;
            add_unit(16'hD800 + {6'd0, off[19:10]});
            add_unit(16'hDC00 + {6'd0, c[9:0]});
          end else begin
            add_unit(c[15:0]);
          end
          if (last_word) begin
            close_string(u2u_pkg::KIND_DONE, {16'd0, written}, sat_add(word_pos, 32'd1));
            return;
          end
          if (written >= capacity) begin
            if (!keep_counting) begin
              close_string(u2u_pkg::KIND_TOO_SMALL, sat_add({16'd0, written}, 32'd1),
                           sat_add(word_pos, 32'd1));
              return;
            end
            phase      = u2u_pkg::PH_COUNT;
            needed     = {16'd0, written};
            resume_pos = sat_add(word_pos, 32'd1);
          end
          owed[owed.size() - 1].run_end = 1'b1;
          word_pos = sat_add(word_pos, 32'd1);
          return;
        end
      end
      if (bad) begin
        close_string(u2u_pkg::KIND_INVALID, '0, word_pos);
        return;
      end
      needed = sat_add(needed, (c > 32'h0000_FFFF) ? 32'd2 : 32'd1);
      if (last_word) begin
        close_string(u2u_pkg::KIND_TOO_SMALL, needed, resume_pos);
        return;
      end
      word_pos = sat_add(word_pos, 32'd1);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [15:0] unit_value,
                               logic [31:0] ret, logic [31:0] res,
                               logic [15:0] units, logic last);
      utf16_result_t exp_r;
      if (owed.size() == 0) begin
        $error("result with nothing outstanding: kind %0d unit 0x%0h", kind, unit_value);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      compare_field("kind", {30'd0, exp_r.kind}, {30'd0, kind});
      compare_field("unit_value", {16'd0, exp_r.unit_value}, {16'd0, unit_value});
      compare_field("return_size", exp_r.return_size, ret);
      compare_field("resume_index", exp_r.resume_index, res);
      compare_field("units_written", {16'd0, exp_r.units_written}, {16'd0, units});
      compare_field("run_end", {31'd0, exp_r.run_end}, {31'd0, last});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  u2u_in_if  in_if();
  u2u_out_if out_if();
  u2u_cfg_if cfg_if();

  utf32_to_utf16_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  utf16_scoreboard sb = new();

  bit calm;
  bit hold_pending;
  bit cur_zero_term;
  bit cur_swap_in;

  always #5 clk = ~clk;

  // Monitor: registers, accepted words and results, all sampled at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_register(cfg_if.index, cfg_if.data);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_word(in_if.code_word, in_if.end_of_string);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.kind, out_if.unit_value, out_if.return_size,
                        out_if.resume_index, out_if.units_written, out_if.run_end);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, and one long stall that lets the block fill up.
  initial begin : receiver
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] swap32(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Valid stays high from one request to the next unless a gap is inserted.
  task automatic send_word(input logic [31:0] w, input logic flag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.code_word     <= w;
    in_if.end_of_string <= flag;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Sends a code point as the block expects to see it on the wire.
  task automatic send_point(input logic [31:0] cp, input logic flag);
    send_word(cur_swap_in ? swap32(cp) : cp, flag);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] cap, input bit creq, input bit zt,
                              input bit si, input bit so);
    logic [2:0]  idx [5];
    logic [31:0] val [5];
    logic [31:0] junk;
    junk   = $urandom;
    idx[0] = u2u_pkg::CFG_OUT_CAPACITY;    val[0] = {junk[15:0], cap};
    idx[1] = u2u_pkg::CFG_COUNT_REQUIRED;  val[1] = {junk[31:1], creq};
    idx[2] = u2u_pkg::CFG_ZERO_TERMINATED; val[2] = {junk[30:0], zt};
    idx[3] = u2u_pkg::CFG_SWAP_INPUT;      val[3] = {junk[29:0], junk[31], si};
    idx[4] = u2u_pkg::CFG_SWAP_OUTPUT;     val[4] = {junk[28:0], junk[31:30], so};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
    end
    cfg_if.valid  <= 1'b0;
    cur_zero_term = zt;
    cur_swap_in   = si;
  endtask

  // One string of random content; mostly valid, with some bad words and
  // stray zeros that cut it short when strings are zero-terminated.
  task automatic send_random_string(output int count);
    int          len;
    int          r;
    logic [31:0] cp;
    len   = $urandom_range(1, 7);
    count = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        cp = $urandom_range(0, 1) ? $urandom_range(1, 32'hD7FF)
                                  : $urandom_range(32'hE000, 32'hFFFF);
      end else if (r < 70) begin
        cp = $urandom_range(32'h1_0000, 32'h10_FFFF);
      end else if (r < 82) begin
        cp = $urandom_range(1, 32'h7F);
      end else if (r < 87) begin
        cp = $urandom_range(32'hD800, 32'hDFFF);
      end else if (r < 92) begin
        cp = $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
      end else if (r < 96) begin
        cp = $urandom;
      end else begin
        cp = 32'd0;
      end
      send_point(cp, cur_zero_term ? 1'($urandom_range(0, 1)) : (i == len - 1));
      count++;
    end
    if (cur_zero_term) begin
      send_point(32'd0, 1'($urandom_range(0, 1)));
      count++;
    end
  endtask

  initial begin : stimulus
    int          sent;
    int          n;
    logic [15:0] cap;
    in_if.valid         <= 1'b0;
    in_if.code_word     <= '0;
    in_if.end_of_string <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    rst_n               <= 1'b0;
    calm          = 1'b0;
    hold_pending  = 1'b0;
    cur_zero_term = 1'b1;
    cur_swap_in   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Code point boundaries, then each kind of bad word.
    apply_config(16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(32'h41, 1'b1);
    send_point(32'hFFFF, 1'b0);
    send_point(32'h1_0000, 1'b0);
    send_point(32'h10_FFFF, 1'b0);
    send_point(32'hD7FF, 1'b0);
    send_point(32'hE000, 1'b0);
    send_point(32'h0, 1'b0);
    send_point(32'hD800, 1'b0);
    send_point(32'hDFFF, 1'b0);
    send_point(32'h11_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 1'b1);
    drain();

    // Room filled exactly by a pair, then a pair meeting a single free unit.
    apply_config(16'd3, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(32'h41, 1'b0);
    send_point(32'h1_0000, 1'b0);
    send_point(32'h42, 1'b0);
    send_point(32'h43, 1'b0);
    send_point(32'h1_0437, 1'b0);
    drain();

    // Counting on past a pair without room, ended by a bad word.
    apply_config(16'd2, 1'b1, 1'b1, 1'b0, 1'b0);
    send_point(32'h41, 1'b0);
    send_point(32'h1_0000, 1'b0);
    send_point(32'h42, 1'b0);
    send_point(32'hD800, 1'b0);
    drain();

    // Zero room: the string is only counted.
    apply_config(16'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_point(32'h41, 1'b0);
    send_point(32'h1_F600, 1'b0);
    send_point(32'h0, 1'b0);
    drain();

    // Flagged strings with both swaps; the room is lowered in mid-string.
    apply_config(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1);
    send_point(32'h41, 1'b0);
    send_point(32'h1_F600, 1'b0);
    drain();
    apply_config(16'd1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_point(32'h42, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 5))
        0:       cap = 16'd0;
        1:       cap = 16'd1;
        2:       cap = 16'($urandom_range(2, 8));
        3:       cap = 16'hFFFF;
        4:       cap = 16'($urandom_range(0, 65535));
        default: cap = 16'($urandom_range(9, 20));
      endcase
      if (p == 0) begin
        cap = 16'hFFFF;
        hold_pending = 1'b1;
      end
      calm = (p == 4);
      apply_config(cap, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_string(n);
        sent += n;
      end
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.owed.size() != 0) begin
        $error("%0d expected results never arrived", sb.owed.size());
      end
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/u2u_pkg.sv
rtl/u2u_in_if.sv
rtl/u2u_out_if.sv
rtl/u2u_cfg_if.sv
rtl/u2u_cfg_regs.sv
rtl/u2u_front.sv
rtl/u2u_queue.sv
rtl/u2u_back.sv
rtl/utf32_to_utf16_converter.sv
bench/testbench.sv
